### hw/rtl/tatu_pkg.sv
// Shared constants for the thermistor ADC to temperature unit.
// Holds widths and Horner coefficients; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tatu_pkg;
  localparam int SAMPLE_W = 10;
  localparam int RB_W = 16;
  localparam int RES_W = 32;
  localparam int NUM_W = SAMPLE_W + RB_W + 8;
  localparam int ACC_W = 128;
  localparam int TEMP_W = 16;
  localparam int ADC_FULL_SCALE_DEF = 1024;
  localparam int NUM_STEPS = 4;
  localparam logic [RB_W-1:0] RB_RESET = 16'd10000;

  localparam logic [ACC_W-1:0] COEF4 = 128'd0 - 128'd43386;
  localparam logic [ACC_W-1:0] COEF3 = 128'd2632103193;
  localparam logic [ACC_W-1:0] COEF2 = 128'd0 - 128'd65199020804340;
  localparam logic [ACC_W-1:0] COEF1 = 128'd981222715650100000;
  localparam logic [ACC_W-1:0] COEF0 =
    128'd0 - {64'd273, 64'd7395299699150159243};

  function automatic logic [ACC_W-1:0] step_coef(input logic [1:0] k);
    logic [ACC_W-1:0] c;
    unique case (k)
      2'd0: c = COEF3;
      2'd1: c = COEF2;
      2'd2: c = COEF1;
      default: c = COEF0;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/tatu_div.sv
// Pipelined restoring divider: resistance = sample*rb*256/(full_scale-sample).
// Depends on tatu_pkg; one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module tatu_div #(
  parameter int ADC_FULL_SCALE = tatu_pkg::ADC_FULL_SCALE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_vld,
  input  wire logic [tatu_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [tatu_pkg::RB_W-1:0]     rb,
  output logic                               out_vld,
  output logic [tatu_pkg::RES_W-1:0]         res
);
  import tatu_pkg::*;
  localparam int DW = $clog2(ADC_FULL_SCALE + 1);
  localparam int NS = NUM_W;

  logic            v_r    [0:NS+1];
  logic [NUM_W-1:0] num_r [0:NS];
  logic [NUM_W-1:0] q_r   [0:NS];
  logic [DW-1:0]   rem_r  [0:NS];
  logic [DW-1:0]   d_r    [0:NS];
  logic            ov_r   [0:NS];
  logic [RES_W-1:0] res_r;

  logic [NUM_W-1:0] num_nxt [1:NS];
  logic [NUM_W-1:0] q_nxt   [1:NS];
  logic [DW-1:0]   rem_nxt  [1:NS];
  logic [DW:0]     rem2     [1:NS];
  logic            ge       [1:NS];
  logic [RB_W+SAMPLE_W-1:0] prod;

  assign prod = (RB_W+SAMPLE_W)'(sample) * (RB_W+SAMPLE_W)'(rb);

  always_comb begin
    for (int i = 1; i <= NS; i++) begin
      rem2[i] = {rem_r[i-1], num_r[i-1][NUM_W-1]};
      ge[i] = rem2[i] >= {1'b0, d_r[i-1]};
      rem_nxt[i] = ge[i] ? DW'(rem2[i] - {1'b0, d_r[i-1]}) : DW'(rem2[i]);
      num_nxt[i] = {num_r[i-1][NUM_W-2:0], 1'b0};
      q_nxt[i] = {q_r[i-1][NUM_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS + 1; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
      for (int i = 1; i <= NS + 1; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= {prod, 8'd0};
      q_r[0] <= '0;
      rem_r[0] <= '0;
      d_r[0] <= DW'(32'(ADC_FULL_SCALE) - 32'(sample));
      ov_r[0] <= 32'(sample) >= 32'(ADC_FULL_SCALE);
      for (int i = 1; i <= NS; i++) begin
        num_r[i] <= num_nxt[i];
        q_r[i] <= q_nxt[i];
        rem_r[i] <= rem_nxt[i];
        d_r[i] <= d_r[i-1];
        ov_r[i] <= ov_r[i-1];
      end
      res_r <= (ov_r[NS] || (q_r[NS][NUM_W-1:RES_W] != '0)) ? '1 : q_r[NS][RES_W-1:0];
    end
  end

  assign out_vld = v_r[NS+1];
  assign res = res_r;
endmodule
`default_nettype wire

### hw/rtl/tatu_horner_step.sv
// One Horner step: acc_out = sgn(acc)*floor(|acc|*res/256) + coef, four stages.
// Depends on tatu_pkg; multiply split into four 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none
module tatu_horner_step (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_vld,
  input  wire logic [tatu_pkg::ACC_W-1:0] acc,
  input  wire logic [tatu_pkg::RES_W-1:0] res,
  input  wire logic [tatu_pkg::ACC_W-1:0] coef,
  output logic                            out_vld,
  output logic [tatu_pkg::ACC_W-1:0]      acc_out,
  output logic [tatu_pkg::RES_W-1:0]      res_out
);
  import tatu_pkg::*;

  logic [3:0]       v_r;
  logic             neg1_r, neg2_r, neg3_r;
  logic [ACC_W-1:0] mag1_r;
  logic [RES_W-1:0] res1_r, res2_r, res3_r, res4_r;
  logic [63:0]      pp_r [0:3];
  logic [ACC_W-9:0] sh3_r;
  logic [ACC_W-1:0] acc4_r;
  logic [ACC_W-1:0] sum;

  assign sum = {pp_r[2], pp_r[0]} + {pp_r[3][31:0], pp_r[1], 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= acc[ACC_W-1];
      mag1_r <= acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;
      res1_r <= res;
      for (int j = 0; j < 4; j++) begin
        pp_r[j] <= 64'(mag1_r[32*j +: 32]) * 64'(res1_r);
      end
      neg2_r <= neg1_r;
      res2_r <= res1_r;
      sh3_r <= sum[ACC_W-1:8];
      neg3_r <= neg2_r;
      res3_r <= res2_r;
      acc4_r <= neg3_r ? (coef - {8'd0, sh3_r}) : (coef + {8'd0, sh3_r});
      res4_r <= res3_r;
    end
  end

  assign out_vld = v_r[3];
  assign acc_out = acc4_r;
  assign res_out = res4_r;
endmodule
`default_nettype wire

### hw/rtl/tatu_sat.sv
// Truncate the Q64.64 polynomial value to whole degrees and saturate to 16 bits.
// Depends on tatu_pkg; two stages.
`timescale 1ns / 1ps
`default_nettype none
module tatu_sat (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_vld,
  input  wire logic [tatu_pkg::ACC_W-1:0]  acc,
  output logic                             out_vld,
  output logic [tatu_pkg::TEMP_W-1:0]      temp,
  output logic                             sat
);
  import tatu_pkg::*;

  logic [1:0]       v_r;
  logic             neg_r;
  logic [63:0]      hi_r;
  logic [ACC_W-1:0] mag;
  logic [TEMP_W-1:0] temp_r, temp_nxt;
  logic             sat_r, sat_nxt;

  assign mag = acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;

  always_comb begin
    sat_nxt = 1'b0;
    if (neg_r) begin
      if (hi_r > 64'd32768) begin
        temp_nxt = 16'h8000;
        sat_nxt = 1'b1;
      end else begin
        temp_nxt = 16'd0 - hi_r[TEMP_W-1:0];
      end
    end else begin
      if (hi_r > 64'd32767) begin
        temp_nxt = 16'h7FFF;
        sat_nxt = 1'b1;
      end else begin
        temp_nxt = hi_r[TEMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= acc[ACC_W-1];
      hi_r <= mag[ACC_W-1:64];
      temp_r <= temp_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_vld = v_r[1];
  assign temp = temp_r;
  assign sat = sat_r;
endmodule
`default_nettype wire

### hw/rtl/thermistor_adc_to_temperature_unit.sv
// Thermistor ADC sample to temperature, top level. Uses tatu_pkg, tatu_div,
// tatu_horner_step and tatu_sat.
// Pipeline order: divider, Horner steps, saturation, then the output register.
// Throughput: one transaction per cycle while in_stall is low; a skid
// register absorbs one result.
// Reset: synchronous active-low rst_n empties the pipeline, series_resistance = 10000.
`timescale 1ns / 1ps
`default_nettype none
module thermistor_adc_to_temperature_unit #(
  parameter int ADC_FULL_SCALE = tatu_pkg::ADC_FULL_SCALE_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tatu_pkg::RB_W-1:0]          cfg_series_resistance,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [tatu_pkg::SAMPLE_W-1:0]      in_raw_sample,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [tatu_pkg::TEMP_W-1:0]      out_temperature,
  output logic                                    out_saturated
);
  import tatu_pkg::*;

  logic [RB_W-1:0]   rb_r;
  logic              en;
  logic              div_vld;
  logic [RES_W-1:0]  div_res;
  logic              stp_vld [0:NUM_STEPS];
  logic [ACC_W-1:0]  stp_acc [0:NUM_STEPS];
  logic [RES_W-1:0]  stp_res [0:NUM_STEPS];
  logic              p_vld;
  logic [TEMP_W-1:0] p_temp;
  logic              p_sat;
  logic              out_vld_r, skid_full_r;
  logic [TEMP_W-1:0] out_temp_r, skid_temp_r;
  logic              out_sat_r, skid_sat_r;
  logic              take, emerge;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r <= RB_RESET;
    end else if (cfg_valid) begin
      rb_r <= cfg_series_resistance;
    end
  end

  assign en = !skid_full_r;
  assign in_stall = skid_full_r;

  tatu_div #(.ADC_FULL_SCALE(ADC_FULL_SCALE)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_valid), .sample(in_raw_sample), .rb(rb_r),
    .out_vld(div_vld), .res(div_res)
  );

  assign stp_vld[0] = div_vld;
  assign stp_acc[0] = COEF4;
  assign stp_res[0] = div_res;

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    tatu_horner_step u_step (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_vld(stp_vld[k]), .acc(stp_acc[k]), .res(stp_res[k]),
      .coef(step_coef(2'(k))),
      .out_vld(stp_vld[k+1]), .acc_out(stp_acc[k+1]), .res_out(stp_res[k+1])
    );
  end

  tatu_sat u_sat (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(stp_vld[NUM_STEPS]), .acc(stp_acc[NUM_STEPS]),
    .out_vld(p_vld), .temp(p_temp), .sat(p_sat)
  );

  assign take = out_vld_r && !out_stall;
  assign emerge = en && p_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      priority if (skid_full_r) begin
        if (take) begin
          skid_full_r <= 1'b0;
        end
      end else if (emerge) begin
        if (!out_vld_r || take) begin
          out_vld_r <= 1'b1;
        end else begin
          skid_full_r <= 1'b1;
        end
      end else if (take) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (take) begin
        out_temp_r <= skid_temp_r;
        out_sat_r <= skid_sat_r;
      end
    end else if (emerge) begin
      if (!out_vld_r || take) begin
        out_temp_r <= p_temp;
        out_sat_r <= p_sat;
      end else begin
        skid_temp_r <= p_temp;
        skid_sat_r <= p_sat;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_temperature = out_temp_r;
  assign out_saturated = out_sat_r;

  a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_vld_r) else $error("skid full with empty output");
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_vld_r && out_stall && p_vld))
    else $error("skid filled without a stalled output");
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_sat_r) |->
      (out_temp_r == 16'h7FFF || out_temp_r == 16'h8000))
    else $error("saturated transaction with unsaturated value");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |=> out_vld_r)
    else $error("stalled transaction dropped");
endmodule
`default_nettype wire
